/* src/cbtm_pkg.sv */
// Shared types and constants of the channel busy-time monitor.
`default_nettype none
package cbtm_pkg;
	localparam int MAX_SLOTS = 16;
	localparam int DEF_NUM_CHANNELS = 16;

	typedef enum logic [2:0] {
		REQ_CREATE = 3'd0,
		REQ_DELETE = 3'd1,
		REQ_START  = 3'd2,
		REQ_END    = 3'd3,
		REQ_REPORT = 3'd4
	} req_code_t;

	typedef enum logic [1:0] {
		KIND_CREATED = 2'd0,
		KIND_FULL    = 2'd1,
		KIND_ROW     = 2'd2
	} kind_t;

	// One table entry as held in the channel memory.
	typedef struct packed {
		logic [31:0] busy;
		logic [31:0] mark;
		logic [31:0] events;
	} entry_t;
endpackage
`default_nettype wire

/* src/cbtm_if.sv */
// Valid/ready channels for requests and results of the monitor.
`default_nettype none
interface cbtm_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  req_type;
	logic [3:0]  channel;
	logic [31:0] timestamp;
	modport source (output valid, req_type, channel, timestamp, input ready);
	modport sink (input valid, req_type, channel, timestamp, output ready);
endinterface

interface cbtm_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [3:0]  slot;
	logic [15:0] utilization;
	logic [31:0] avg_busy;
	logic [31:0] event_count;
	logic        last;
	modport source (output valid, kind, slot, utilization, avg_busy, event_count, last,
		input ready);
	modport sink (input valid, kind, slot, utilization, avg_busy, event_count, last,
		output ready);
endinterface
`default_nettype wire

/* src/cbtm_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none
module cbtm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0]      rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

/* src/channel_busy_time_monitor.sv */
// Top level of the channel busy-time monitor.
//
// Channel | Direction | Transaction carries
// req     | in        | req_type, channel, timestamp
// rsp     | out       | kind, slot, utilization, avg_busy, event_count, last
//
// Delete and unknown requests finish in the idle state; create goes on to emit, start and end to a modify state.
// A report scans every slot in turn and then closes the period; each used slot is
// loaded, runs through the shared bit-serial divider when needed (16 utilization bits,
// 32 average bits) and is emitted.
// Totals live in one memory; valid bits for the slots are cleared by reset at once.
// A result waits in the output register while the sequencer stalls for it.
`default_nettype none
module channel_busy_time_monitor #(
	parameter int NUM_CHANNELS = cbtm_pkg::DEF_NUM_CHANNELS
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	cbtm_req_if.sink    req,
	cbtm_rsp_if.source  rsp
);
	import cbtm_pkg::*;

	localparam int NSLOT = (NUM_CHANNELS < MAX_SLOTS) ? NUM_CHANNELS : MAX_SLOTS;
	localparam int AW = (NSLOT > 1) ? $clog2(NSLOT) : 1;
	localparam int IW = AW + 1;
	localparam int EW = $bits(entry_t);

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_MOD  = 7'b0000010,
		ST_SCAN = 7'b0000100,
		ST_LOAD = 7'b0001000,
		ST_DIVU = 7'b0010000,
		ST_DIVA = 7'b0100000,
		ST_EMIT = 7'b1000000
	} state_t;

	state_t          state_q;
	logic [NSLOT-1:0] used_q;
	logic [31:0]     period_start_q;
	logic [31:0]     period_q;
	logic [31:0]     ts_q;
	logic [AW-1:0]   ch_q;
	logic            is_end_q;
	logic            rpt_q;
	logic [IW-1:0]   idx_q;
	logic [31:0]     busy_q;
	logic [31:0]     ev_q;
	logic [15:0]     util_q;
	logic [31:0]     avg_q;
	kind_t           kind_q;
	logic [3:0]      slot_q;
	logic            last_q;
	logic [31:0]     div_rem_q;
	logic [31:0]     div_quo_q;
	logic [31:0]     div_den_q;
	logic [5:0]      cnt_q;
	logic            out_valid_q;

	logic            accept;
	logic            addr_ok;
	logic            free_found;
	logic [AW-1:0]   free_idx;
	logic            more_used;
	logic            ram_we;
	logic [AW-1:0]   ram_waddr;
	entry_t          ram_wdata;
	logic            ram_re;
	logic [AW-1:0]   ram_raddr;
	logic [EW-1:0]   ram_rdata;
	entry_t          rd;
	logic [32:0]     sum;
	logic [32:0]     div_r2;
	logic            div_ge;
	logic [31:0]     div_rem_nx;
	logic [31:0]     div_quo_nx;
	logic            emit_go;

	assign rd = entry_t'(ram_rdata);
	assign accept = req.valid && req.ready;
	assign req.ready = (state_q == ST_IDLE);
	assign addr_ok = ({28'd0, req.channel} < 32'(NSLOT)) && used_q[req.channel[AW-1:0]];
	assign emit_go = (state_q == ST_EMIT) && (!out_valid_q || rsp.ready);

	// Lowest free slot for a create.
	always_comb begin
		free_found = 1'b0;
		free_idx = '0;
		for (int i = NSLOT - 1; i >= 0; i--) begin
			if (!used_q[i]) begin
				free_found = 1'b1;
				free_idx = AW'(i);
			end
		end
	end

	// Whether a used slot follows the current report slot.
	always_comb begin
		more_used = 1'b0;
		for (int i = 0; i < NSLOT; i++) begin
			if ((IW'(i) > idx_q) && used_q[i]) begin
				more_used = 1'b1;
			end
		end
	end

	// Saturating busy total for an end-busy transaction.
	assign sum = {1'b0, rd.busy} + {1'b0, ts_q - rd.mark};

	// One restoring step of the shared divider.
	assign div_r2 = {div_rem_q, div_quo_q[31]};
	assign div_ge = (div_r2 >= {1'b0, div_den_q});
	assign div_rem_nx = div_ge ? 32'(div_r2 - {1'b0, div_den_q}) : div_r2[31:0];
	assign div_quo_nx = {div_quo_q[30:0], div_ge};

	// Memory access control.
	always_comb begin
		ram_we = 1'b0;
		ram_waddr = '0;
		ram_wdata = '0;
		ram_re = 1'b0;
		ram_raddr = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (req.req_type)
						REQ_CREATE: begin
							ram_we = free_found;
							ram_waddr = free_idx;
							ram_wdata = '{busy: 32'd0, mark: period_start_q, events: 32'd0};
						end
						REQ_START, REQ_END: begin
							ram_re = addr_ok;
							ram_raddr = req.channel[AW-1:0];
						end
						default: begin
						end
					endcase
				end
			end
			ST_MOD: begin
				ram_we = 1'b1;
				ram_waddr = ch_q;
				if (is_end_q) begin
					ram_wdata.busy = sum[32] ? '1 : sum[31:0];
					ram_wdata.events = (rd.events == '1) ? rd.events : rd.events + 32'd1;
				end else begin
					ram_wdata.busy = rd.busy;
					ram_wdata.events = rd.events;
				end
				ram_wdata.mark = ts_q;
			end
			ST_SCAN: begin
				ram_re = (idx_q < IW'(NSLOT)) && used_q[idx_q[AW-1:0]];
				ram_raddr = idx_q[AW-1:0];
			end
			ST_LOAD: begin
				ram_we = 1'b1;
				ram_waddr = idx_q[AW-1:0];
				ram_wdata = '{busy: 32'd0, mark: ts_q, events: 32'd0};
			end
			default: begin
			end
		endcase
	end

	cbtm_ram #(.WIDTH(EW), .DEPTH(NSLOT), .AW(AW)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Sequencer, divider and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			used_q <= '0;
			period_start_q <= '0;
			out_valid_q <= 1'b0;
			idx_q <= '0;
			cnt_q <= '0;
			rpt_q <= 1'b0;
		end else begin
			// The output register fills on an emit and empties when taken.
			if (emit_go) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (req.req_type)
							REQ_CREATE: begin
								if (free_found) begin
									used_q[free_idx] <= 1'b1;
									kind_q <= KIND_CREATED;
									slot_q <= 4'(free_idx);
								end else begin
									kind_q <= KIND_FULL;
									slot_q <= '0;
								end
								util_q <= '0;
								avg_q <= '0;
								ev_q <= '0;
								last_q <= 1'b0;
								rpt_q <= 1'b0;
								state_q <= ST_EMIT;
							end
							REQ_DELETE: begin
								if (addr_ok) begin
									used_q[req.channel[AW-1:0]] <= 1'b0;
								end
							end
							REQ_START, REQ_END: begin
								if (addr_ok) begin
									ch_q <= req.channel[AW-1:0];
									ts_q <= req.timestamp;
									is_end_q <= (req.req_type == REQ_END);
									state_q <= ST_MOD;
								end
							end
							REQ_REPORT: begin
								ts_q <= req.timestamp;
								period_q <= req.timestamp - period_start_q;
								idx_q <= '0;
								state_q <= ST_SCAN;
							end
							default: begin
							end
						endcase
					end
				end
				ST_MOD: begin
					state_q <= ST_IDLE;
				end
				ST_SCAN: begin
					if (idx_q >= IW'(NSLOT)) begin
						period_start_q <= ts_q;
						state_q <= ST_IDLE;
					end else if (used_q[idx_q[AW-1:0]]) begin
						state_q <= ST_LOAD;
					end else begin
						idx_q <= idx_q + IW'(1);
					end
				end
				ST_LOAD: begin
					busy_q <= rd.busy;
					ev_q <= rd.events;
					kind_q <= KIND_ROW;
					slot_q <= 4'(idx_q);
					last_q <= !more_used;
					rpt_q <= 1'b1;
					if ((period_q != '0) && (rd.busy < period_q)) begin
						div_rem_q <= rd.busy;
						div_quo_q <= '0;
						div_den_q <= period_q;
						cnt_q <= 6'd16;
						state_q <= ST_DIVU;
					end else begin
						util_q <= (rd.busy != '0) ? '1 : '0;
						if (rd.events == '0) begin
							avg_q <= '0;
							state_q <= ST_EMIT;
						end else begin
							div_rem_q <= '0;
							div_quo_q <= rd.busy;
							div_den_q <= rd.events;
							cnt_q <= 6'd32;
							state_q <= ST_DIVA;
						end
					end
				end
				ST_DIVU: begin
					if (cnt_q == 6'd1) begin
						util_q <= div_quo_nx[15:0];
						if (ev_q == '0) begin
							avg_q <= '0;
							state_q <= ST_EMIT;
						end else begin
							div_rem_q <= '0;
							div_quo_q <= busy_q;
							div_den_q <= ev_q;
							cnt_q <= 6'd32;
							state_q <= ST_DIVA;
						end
					end else begin
						div_rem_q <= div_rem_nx;
						div_quo_q <= div_quo_nx;
						cnt_q <= cnt_q - 6'd1;
					end
				end
				ST_DIVA: begin
					div_rem_q <= div_rem_nx;
					div_quo_q <= div_quo_nx;
					cnt_q <= cnt_q - 6'd1;
					if (cnt_q == 6'd1) begin
						avg_q <= div_quo_nx;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (emit_go) begin
						rsp.kind <= kind_q;
						rsp.slot <= slot_q;
						rsp.utilization <= util_q;
						rsp.avg_busy <= avg_q;
						rsp.event_count <= ev_q;
						rsp.last <= last_q;
						if (rpt_q) begin
							idx_q <= idx_q + IW'(1);
							state_q <= ST_SCAN;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid = out_valid_q;

`ifndef SYNTHESIS
	// The divider count never exceeds a full average division.
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 6'd32) else $error("divider count out of range");

	// The partial remainder stays below the divisor while dividing.
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_DIVU) || (state_q == ST_DIVA)) |-> (div_rem_q < div_den_q))
		else $error("divider remainder not below divisor");

	// The slot table does not change during a report sweep.
	a_used_stable: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_SCAN) || (state_q == ST_LOAD) || (state_q == ST_DIVU)
			|| (state_q == ST_DIVA) || (state_q == ST_EMIT && rpt_q)) |=> $stable(used_q))
		else $error("slot table changed during report");
`endif
endmodule
`default_nettype wire

/* test/cbtm_tb_if.sv */
// Expected-result types shared by the testbench of the monitor.
`timescale 1ns / 100ps
package cbtm_tb_types;
	import cbtm_pkg::*;

	// One expected result row of the monitor.
	typedef struct {
		kind_t       kind;
		logic [3:0]  slot;
		logic [15:0] utilization;
		logic [31:0] avg_busy;
		logic [31:0] event_count;
		logic        last;
	} row_t;
endpackage

/* test/testbench.sv */
// Self-checking testbench of the channel busy-time monitor.
`timescale 1ns / 100ps
module testbench;
	import cbtm_pkg::*;
	import cbtm_tb_types::*;

	localparam int NSLOT = 16;
	localparam int STALL_LIMIT = 20000;

	logic clk;
	logic arst_n;
	cbtm_req_if req_ch ();
	cbtm_rsp_if rsp_ch ();

	channel_busy_time_monitor #(.NUM_CHANNELS(16)) dut (
		.clk(clk), .arst_n(arst_n), .req(req_ch.sink), .rsp(rsp_ch.source)
	);

	// Predicted table contents.
	logic        used_q [NSLOT];
	logic [31:0] busy_q [NSLOT];
	logic [31:0] mark_q [NSLOT];
	logic [31:0] events_q [NSLOT];
	logic [31:0] period_q;
	row_t        pending_rows [$];

	int errors;
	int idle_cycles;
	bit timed_out;
	bit calm;
	logic [31:0] now_ticks;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		$display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// Utilization in Q0.16, saturated.
	function automatic logic [15:0] util_q16(input logic [31:0] b, input logic [31:0] p);
		logic [63:0] q;
		if (p == 0)
			return (b != 0) ? 16'hFFFF : 16'h0;
		q = {b, 16'h0} / {32'h0, p};
		return (q > 64'hFFFF) ? 16'hFFFF : q[15:0];
	endfunction

	// Applies one request to the predicted table and queues the rows it yields.
	task automatic predict_request(input logic [2:0] rq, input logic [3:0] ch,
		input logic [31:0] t);
		row_t r;
		logic [32:0] sum;
		int n;
		bit found;
		n = 0;
		found = 0;
		r = '{KIND_CREATED, 4'd0, 16'd0, 32'd0, 32'd0, 1'b0};
		case (rq)
			REQ_CREATE: begin
				for (int i = 0; i < NSLOT; i++) begin
					if (!found && !used_q[i]) begin
						found = 1;
						used_q[i] = 1;
						busy_q[i] = 0;
						events_q[i] = 0;
						mark_q[i] = period_q;
						r.slot = i[3:0];
					end
				end
				if (!found)
					r.kind = KIND_FULL;
				pending_rows.push_back(r);
			end
			REQ_DELETE: if (used_q[ch]) used_q[ch] = 0;
			REQ_START: if (used_q[ch]) mark_q[ch] = t;
			REQ_END: begin
				if (used_q[ch]) begin
					sum = {1'b0, busy_q[ch]} + {1'b0, t - mark_q[ch]};
					busy_q[ch] = sum[32] ? 32'hFFFFFFFF : sum[31:0];
					if (events_q[ch] != 32'hFFFFFFFF)
						events_q[ch]++;
					mark_q[ch] = t;
				end
			end
			REQ_REPORT: begin
				for (int i = 0; i < NSLOT; i++) begin
					if (used_q[i]) begin
						r.kind = KIND_ROW;
						r.slot = i[3:0];
						r.utilization = util_q16(busy_q[i], t - period_q);
						r.avg_busy = (events_q[i] != 0) ? busy_q[i] / events_q[i] : 0;
						r.event_count = events_q[i];
						r.last = 0;
						pending_rows.push_back(r);
						n++;
						busy_q[i] = 0;
						events_q[i] = 0;
						mark_q[i] = t;
					end
				end
				if (n > 0)
					pending_rows[pending_rows.size() - 1].last = 1;
				period_q = t;
			end
			default: ;
		endcase
	endtask

	// Sends one transaction and updates the prediction when it is taken.
	// Valid stays high after the transaction until the next idle gap or drain.
	task automatic send_request(input logic [2:0] rq, input logic [3:0] ch,
		input logic [31:0] t);
		if (!calm && $urandom_range(0, 3) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.req_type <= rq;
		req_ch.channel <= ch;
		req_ch.timestamp <= t;
		do @(posedge clk); while (!req_ch.ready);
		predict_request(rq, ch, t);
		@(negedge clk);
	endtask

	// Advances time by a random step, sometimes huge so that totals saturate.
	function automatic logic [31:0] next_tick();
		case ($urandom_range(0, 9))
			0: now_ticks += $urandom;
			1: now_ticks += 0;
			default: now_ticks += $urandom_range(1, 300);
		endcase
		return now_ticks;
	endfunction

	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		while (pending_rows.size() != 0) @(negedge clk);
	endtask

	task automatic test_directed();
		// Report with nothing used, creates until full, then field extremes.
		send_request(REQ_REPORT, 4'd0, 32'd0);
		for (int i = 0; i < 17; i++) send_request(REQ_CREATE, 4'd0, 32'd0);
		send_request(REQ_START, 4'd15, 32'hFFFFFF00);
		send_request(REQ_END, 4'd15, 32'h00000100);
		send_request(REQ_END, 4'd0, 32'hFFFFFFFF);
		send_request(REQ_END, 4'd0, 32'hFFFFFFFF);
		send_request(3'd7, 4'd3, 32'h5);
		send_request(3'd5, 4'd3, 32'h5);
		// Zero-length period after busy time.
		send_request(REQ_REPORT, 4'd0, 32'h0);
		send_request(REQ_REPORT, 4'd0, 32'h0);
		send_request(REQ_DELETE, 4'd15, 32'h0);
		send_request(REQ_END, 4'd15, 32'h10);
		send_request(REQ_DELETE, 4'd15, 32'h0);
		send_request(REQ_REPORT, 4'd0, 32'hFFFFFFFF);
		now_ticks = 32'hFFFFFFFF;
		wait_drained();
	endtask

	// Sends one random transaction, mostly starts and ends on random channels.
	task automatic random_request();
		int pick;
		logic [3:0] ch;
		pick = $urandom_range(0, 99);
		ch = 4'($urandom_range(0, 15));
		if (pick < 10) send_request(REQ_CREATE, ch, next_tick());
		else if (pick < 18) send_request(REQ_DELETE, ch, next_tick());
		else if (pick < 50) send_request(REQ_START, ch, next_tick());
		else if (pick < 85) send_request(REQ_END, ch, next_tick());
		else if (pick < 95) send_request(REQ_REPORT, ch, next_tick());
		else send_request(3'($urandom_range(5, 7)), ch, $urandom);
	endtask

	task automatic test_random();
		for (int k = 0; k < 120; k++) begin
			random_request();
			if (k == 60)
				wait_drained();
		end
	endtask

	task automatic test_no_idle();
		calm = 1;
		for (int k = 0; k < 80; k++) random_request();
		send_request(REQ_REPORT, 4'd0, next_tick());
	endtask

	// Result side: random back-pressure and the check against the oldest row.
	initial begin
		row_t w;
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!calm && $urandom_range(0, 5) == 0) begin
				rsp_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(negedge clk);
			end
			rsp_ch.ready <= 1'b1;
			@(posedge clk);
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (pending_rows.size() == 0) begin
					report_mismatch("unexpected result", 32'(rsp_ch.kind), 32'd0);
				end else begin
					w = pending_rows.pop_front();
					if (rsp_ch.kind !== w.kind)
						report_mismatch("kind", 32'(rsp_ch.kind), 32'(w.kind));
					if (rsp_ch.slot !== w.slot)
						report_mismatch("slot", 32'(rsp_ch.slot), 32'(w.slot));
					if (rsp_ch.utilization !== w.utilization)
						report_mismatch("utilization", 32'(rsp_ch.utilization),
							32'(w.utilization));
					if (rsp_ch.avg_busy !== w.avg_busy)
						report_mismatch("avg_busy", rsp_ch.avg_busy, w.avg_busy);
					if (rsp_ch.event_count !== w.event_count)
						report_mismatch("event_count", rsp_ch.event_count, w.event_count);
					if (rsp_ch.last !== w.last)
						report_mismatch("last", 32'(rsp_ch.last), 32'(w.last));
				end
			end
		end
	end

	// Watchdog on cycles without any transaction.
	initial begin
		idle_cycles = 0;
		timed_out = 0;
		forever begin
			@(posedge clk);
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				timed_out = 1;
				$display("FAIL");
				$finish;
			end
		end
	end

	initial begin
		errors = 0;
		calm = 0;
		now_ticks = 0;
		period_q = 0;
		for (int i = 0; i < NSLOT; i++) begin
			used_q[i] = 0;
			busy_q[i] = 0;
			mark_q[i] = 0;
			events_q[i] = 0;
		end
		req_ch.valid = 1'b0;
		req_ch.req_type = REQ_CREATE;
		req_ch.channel = 4'd0;
		req_ch.timestamp = 32'd0;
		arst_n = 1'b0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_random();
		test_no_idle();
		wait_drained();
		repeat (1000) @(negedge clk);
		if (errors == 0 && pending_rows.size() == 0 && !timed_out)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule
